// ===== hdl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register codes, reset values and channel word types of the
// accelerometer shake detector.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int AXIS_W     = 16;
    localparam int MAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;
    localparam int VAR_W      = 30;
    localparam int COOL_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int WINDOW_DEPTH_DEFAULT = 8;
    localparam int DIV_DW_DEFAULT       = 2 * (MAG_W + $clog2(WINDOW_DEPTH_DEFAULT));
    localparam int DIVISOR_DEFAULT      = WINDOW_DEPTH_DEFAULT * WINDOW_DEPTH_DEFAULT;

    localparam logic [VAR_W-1:0]  VAR_MAX        = {VAR_W{1'b1}};
    localparam logic [VAR_W-1:0]  THRESHOLD_RESET = 30'd23488102;
    localparam logic [COOL_W-1:0] COOLDOWN_RESET  = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS        = 8'd1;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [TIME_W-1:0]        time_ms;
    } sample_t;

    typedef struct packed {
        logic             shake_detected;
        logic [VAR_W-1:0] window_variance;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_word_t;

endpackage

// ===== hdl/asd_stream_if.sv =====
// ----------------------------------------------------------------------------
// asd_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface asd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/accel_shake_detector.sv =====
// ----------------------------------------------------------------------------
// accel_shake_detector
// Moving-variance shake detector on accelerometer magnitude.
// ----------------------------------------------------------------------------
// sample: one word per accelerometer reading (x, y, z counts and time_ms).
// result: one word per sample, shake_detected and window_variance.
// cfg:    register writes, index 0 variance_threshold, 1 cooldown_ms; always
//         ready, other indexes are dropped. Write only while idle.
// One sample is processed at a time through bit-serial units: four squarers,
// a square root, the magnitude squarer, the window-sum squarer of
// SUM_W = 16 + log2(WINDOW_DEPTH) bits and a divider.
// The next sample can be accepted only once the result word has been loaded.
// The result sits in an output register, so a new sample is taken while it
// waits; if it is still not taken when the next result is ready, the block
// holds that result in the divider until the receiver is ready.
// Reset loads the register defaults, clears the window sums, slot pointer,
// last shake time and result valid; window memory entries read as zero
// until the write pointer has wrapped once.
// ----------------------------------------------------------------------------
module accel_shake_detector #(
    parameter int WINDOW_DEPTH = asd_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    asd_stream_if.sink   sample,
    asd_stream_if.source result,
    asd_stream_if.sink   cfg
);
    localparam int MAG_W   = asd_pkg::MAG_W;
    localparam int SQ_W    = asd_pkg::SQ_W;
    localparam int VAR_W   = asd_pkg::VAR_W;
    localparam int TIME_W  = asd_pkg::TIME_W;
    localparam int COOL_W  = asd_pkg::COOL_W;
    localparam int LOG_N   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = MAG_W + LOG_N;
    localparam int SQS_W   = 2 * MAG_W + LOG_N;
    localparam int DW      = 2 * SUM_W;
    localparam int DIVISOR = WINDOW_DEPTH * WINDOW_DEPTH;
    localparam logic [LOG_N-1:0] LAST_SLOT = LOG_N'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_ROOT,
        ST_PROD,
        ST_DIFF,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    logic [MAG_W-1:0]  abs_x_reg, abs_y_reg, abs_z_reg;
    logic [TIME_W-1:0] time_reg;
    logic [MAG_W-1:0]  old_reg;
    logic [MAG_W-1:0]  old_rd_reg;
    logic [LOG_N-1:0]  slot_reg;
    logic              wrapped_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQS_W-1:0]  sq_sum_reg, sq_sum_next;
    logic [TIME_W-1:0] last_shake_reg;
    logic [VAR_W-1:0]  thr_reg;
    logic [COOL_W-1:0] cooldown_reg;
    logic              res_valid_reg;
    asd_pkg::result_t  res_data_reg, res_data_next;

    logic [MAG_W-1:0] mem [WINDOW_DEPTH];

    logic sample_acc, cfg_acc, out_free;
    logic load_sq, root_start, root_fin, prod_fin, div_start, res_load;

    logic [2*MAG_W-1:0] px, py, pz, p_old, p_mag;
    logic [DW-1:0]      p_sum;
    logic done_x, done_y, done_z, done_old, done_mag, done_sum;
    logic sq_done, sum_done, root_done, div_done;
    logic [SQ_W-1:0]    sq_total;
    logic [MAG_W-1:0]   root;
    logic [DW-1:0]      a_full, dividend, quot;
    logic [VAR_W-1:0]   var_sat;
    logic [TIME_W-1:0]  elapsed;
    logic               shake;

    function automatic logic [MAG_W-1:0] abs16(input logic [MAG_W-1:0] v);
        abs16 = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    assign sample_acc = sample.valid && sample.ready;
    assign cfg_acc    = cfg.valid && cfg.ready;
    assign out_free   = !res_valid_reg || result.ready;

    assign sq_done  = done_x && done_y && done_z && done_old;
    assign sum_done = done_mag && done_sum;

    always_comb
    begin
        load_sq    = (state_reg == ST_LOAD);
        root_start = (state_reg == ST_SQ) && sq_done;
        root_fin   = (state_reg == ST_ROOT) && root_done;
        prod_fin   = (state_reg == ST_PROD) && sum_done;
        div_start  = (state_reg == ST_DIFF);
        res_load   = (state_reg == ST_DIV) && div_done && out_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (sample_acc) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SQ;
            ST_SQ:   if (root_start) state_next = ST_ROOT;
            ST_ROOT: if (root_fin) state_next = ST_PROD;
            ST_PROD: if (prod_fin) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_DIV;
            ST_DIV:  if (res_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sq_total    = px + py + pz;
        sum_next    = sum_reg - SUM_W'(old_reg) + SUM_W'(root);
        sq_sum_next = sq_sum_reg - SQS_W'(p_old) + SQS_W'(p_mag);
        a_full      = DW'(sq_sum_reg) * DW'(WINDOW_DEPTH);
        dividend    = (a_full > p_sum) ? (a_full - p_sum) : '0;
        var_sat     = (|quot[DW-1:VAR_W]) ? asd_pkg::VAR_MAX : quot[VAR_W-1:0];
        elapsed     = time_reg - last_shake_reg;
        shake       = (var_sat > thr_reg) && (elapsed > TIME_W'(cooldown_reg));
        res_data_next.shake_detected  = shake;
        res_data_next.window_variance = var_sat;
    end

    asd_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_x (
        .clk(clk), .rst_n(rst_n), .start(load_sq),
        .a(abs_x_reg), .b(abs_x_reg), .product(px), .done(done_x)
    );

    asd_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_y (
        .clk(clk), .rst_n(rst_n), .start(load_sq),
        .a(abs_y_reg), .b(abs_y_reg), .product(py), .done(done_y)
    );

    asd_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_z (
        .clk(clk), .rst_n(rst_n), .start(load_sq),
        .a(abs_z_reg), .b(abs_z_reg), .product(pz), .done(done_z)
    );

    asd_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_old (
        .clk(clk), .rst_n(rst_n), .start(load_sq),
        .a(wrapped_reg ? old_rd_reg : '0), .b(wrapped_reg ? old_rd_reg : '0),
        .product(p_old), .done(done_old)
    );

    asd_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(root_start),
        .radicand(sq_total), .root(root), .done(root_done)
    );

    asd_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_mag (
        .clk(clk), .rst_n(rst_n), .start(root_fin),
        .a(root), .b(root), .product(p_mag), .done(done_mag)
    );

    asd_serial_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_sum (
        .clk(clk), .rst_n(rst_n), .start(root_fin),
        .a(sum_next), .b(sum_next), .product(p_sum), .done(done_sum)
    );

    asd_const_div #(.DW(DW), .DIVISOR(DIVISOR)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(dividend), .quotient(quot), .done(div_done)
    );

    // window memory, registered read of the slot about to be replaced
    always_ff @(posedge clk)
    begin
        if (root_fin)
        begin
            mem[slot_reg] <= root;
        end
        old_rd_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            abs_x_reg <= abs16(sample.data.accel_x);
            abs_y_reg <= abs16(sample.data.accel_y);
            abs_z_reg <= abs16(sample.data.accel_z);
            time_reg  <= sample.data.time_ms;
        end
        if (load_sq)
        begin
            old_reg <= wrapped_reg ? old_rd_reg : '0;
        end
        if (res_load)
        begin
            res_data_reg <= res_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            wrapped_reg    <= 1'b0;
            sum_reg        <= '0;
            sq_sum_reg     <= '0;
            last_shake_reg <= '0;
            thr_reg        <= asd_pkg::THRESHOLD_RESET;
            cooldown_reg   <= asd_pkg::COOLDOWN_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                unique case (cfg.data.index)
                    asd_pkg::REG_VARIANCE_THRESHOLD: thr_reg <= cfg.data.wdata[VAR_W-1:0];
                    asd_pkg::REG_COOLDOWN_MS:        cooldown_reg <= cfg.data.wdata[COOL_W-1:0];
                    default: ;
                endcase
            end

            if (root_fin)
            begin
                sum_reg  <= sum_next;
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + LOG_N'(1);
                if (slot_reg == LAST_SLOT)
                begin
                    wrapped_reg <= 1'b1;
                end
            end

            if (prod_fin)
            begin
                sq_sum_reg <= sq_sum_next;
            end

            if (res_load && shake)
            begin
                last_shake_reg <= time_reg;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    a_last_shake_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_shake_reg) |-> $past(res_load))
        else $error("last shake time changed without a result load");

    a_div_after_sum_square: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> $past(sum_done))
        else $error("divider started before the sum square was finished");

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !res_load)
        else $error("result loaded right after a sample was accepted");

endmodule

// ===== hdl/asd_serial_mul.sv =====
// ----------------------------------------------------------------------------
// asd_serial_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module asd_serial_mul #(
    parameter int AW = asd_pkg::MAG_W,
    parameter int BW = asd_pkg::MAG_W
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] product,
    output logic            done
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] p_reg, p_next;
    logic [CW-1:0]    cnt_reg;
    logic [AW:0]      partial;

    always_comb
    begin
        partial = {1'b0, p_reg[AW+BW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        p_next  = {partial, p_reg[BW-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(BW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{AW{1'b0}}, b};
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= p_next;
        end
    end

    assign product = p_reg;
    assign done    = (cnt_reg == '0);
endmodule

// ===== hdl/asd_isqrt.sv =====
// ----------------------------------------------------------------------------
// asd_isqrt
// Floor square root, two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module asd_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [asd_pkg::SQ_W-1:0]   radicand,
    output logic [asd_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    localparam int RW = asd_pkg::ROOT_W;
    localparam int SW = asd_pkg::SQ_W;
    localparam int EW = RW + 1;
    localparam int CW = $clog2(RW + 1);

    logic [SW-1:0] rad_reg;
    logic [EW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg;
    logic [EW+1:0] rem_sh, trial;
    logic          ge;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SW-1:SW-2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? EW'(rem_sh - trial) : EW'(rem_sh);
        root_next = {root_reg[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(RW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
    assign done = (cnt_reg == '0);
endmodule

// ===== hdl/asd_const_div.sv =====
// ----------------------------------------------------------------------------
// asd_const_div
// Restoring divider by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_const_div #(
    parameter int DW      = asd_pkg::DIV_DW_DEFAULT,
    parameter int DIVISOR = asd_pkg::DIVISOR_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic [DW-1:0] quotient,
    output logic          done
);
    localparam int RW = $clog2(DIVISOR);
    localparam int CW = $clog2(DW + 1);
    localparam logic [RW:0] DIVISOR_V = (RW + 1)'(DIVISOR);

    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [CW-1:0] cnt_reg;
    logic [RW:0]   trial;
    logic          ge;

    always_comb
    begin
        trial    = {rem_reg, dq_reg[DW-1]};
        ge       = (trial >= DIVISOR_V);
        rem_next = ge ? RW'(trial - DIVISOR_V) : RW'(trial);
        dq_next  = {dq_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quotient = dq_reg;
    assign done     = (cnt_reg == '0);
endmodule
